/* hdl/mtbpl_pkg.sv */
package mtbpl_pkg;

  localparam int unsigned DataW          = 32;
  localparam int unsigned ShiftW         = 5;
  localparam int unsigned CountOutW      = 5;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned DefTableDepth  = 16;
  localparam int unsigned DefAddrBits    = 32;

  localparam logic [CfgIdxW-1:0] CfgExpectedPattern = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPageShift       = 2'd1;

  localparam logic [DataW-1:0]  ExpectedReset  = 32'hFFFF_FFFF;
  localparam logic [ShiftW-1:0] PageShiftReset = 5'd12;
  localparam logic [DataW-1:0]  CountTop       = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic valid;
    logic hit;
  } tok_ctrl_t;

endpackage

/* hdl/mtbpl_cell.sv */
module mtbpl_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned ENTRY_W  = 32,
  parameter int unsigned CNT_W    = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mtbpl_pkg::tok_ctrl_t  tok_ctrl_i,
  input  logic [ENTRY_W-1:0]    tok_page_i,
  output mtbpl_pkg::tok_ctrl_t  tok_ctrl_o,
  output logic [ENTRY_W-1:0]    tok_page_o,
  input  logic [CNT_W-1:0]      entry_count_i,
  input  logic                  wr_en_i,
  input  logic [ENTRY_W-1:0]    wr_page_i
);
  import mtbpl_pkg::*;

  logic [ENTRY_W-1:0] entry_q;
  logic               entry_hit;
  tok_ctrl_t          tok_ctrl_d;
  tok_ctrl_t          tok_ctrl_q;
  logic [ENTRY_W-1:0] tok_page_q;

  assign entry_hit = (entry_count_i > CNT_W'(CELL_IDX)) && (entry_q == tok_page_i);

  always_comb begin
    tok_ctrl_d.valid = tok_ctrl_i.valid;
    tok_ctrl_d.hit   = tok_ctrl_i.hit | (tok_ctrl_i.valid & entry_hit);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (entry_count_i == CNT_W'(CELL_IDX))) begin
      entry_q <= wr_page_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_ctrl_q <= '0;
    end else begin
      tok_ctrl_q <= tok_ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_page_q <= tok_page_i;
  end

  assign tok_ctrl_o = tok_ctrl_q;
  assign tok_page_o = tok_page_q;

endmodule

/* hdl/memory_test_bad_page_logger_top.sv */
// Channel   Direction  Handshake                  Payload
// cfg       in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
// in        in         in_valid_i / in_stall_o    word_address_i, read_data_i, last_word_i
// out       out        out_valid_o / out_stall_i  mismatch_o .. test_passed_o
//
// A matching word goes from IDLE straight to DONE, and back to IDLE once its result is registered.
// A bad word goes through SEARCH before DONE: its page walks the cell row one cell per cycle.
// One word is in flight at a time; the result register lets the next word in
// while a result is still stalled on the output side.
// Reset clears the bad word count and the table fill count, and restores the configuration
// to its defaults.
module memory_test_bad_page_logger_top #(
  parameter int unsigned TABLE_DEPTH = mtbpl_pkg::DefTableDepth,
  parameter int unsigned ADDR_BITS   = mtbpl_pkg::DefAddrBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mtbpl_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [mtbpl_pkg::DataW-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [mtbpl_pkg::DataW-1:0]         word_address_i,
  input  logic [mtbpl_pkg::DataW-1:0]         read_data_i,
  input  logic                                last_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                mismatch_o,
  output logic                                new_bad_page_o,
  output logic [mtbpl_pkg::DataW-1:0]         page_address_o,
  output logic                                table_overflow_o,
  output logic [mtbpl_pkg::CountOutW-1:0]     bad_page_count_o,
  output logic [mtbpl_pkg::DataW-1:0]         bad_word_total_o,
  output logic                                test_passed_o
);
  import mtbpl_pkg::*;

  localparam int unsigned EntryW = (ADDR_BITS < DataW) ? ADDR_BITS : DataW;
  localparam int unsigned CntW   = $clog2(TABLE_DEPTH + 1);
  localparam logic [DataW-1:0] AddrMask =
    (ADDR_BITS >= DataW) ? {DataW{1'b1}} : DataW'((64'd1 << ADDR_BITS) - 64'd1);

  state_e state_q, state_d;

  logic [DataW-1:0]  expected_q;
  logic [ShiftW-1:0] page_shift_q;

  logic             accept;
  logic             bad_in;
  logic [DataW-1:0] page_in;

  logic [DataW-1:0] page_q;
  logic             bad_q;
  logic             last_q;
  logic             hit_q;

  logic [CntW-1:0]  count_q, count_d;
  logic [DataW-1:0] total_q, total_d;
  logic             room;
  logic             new_page;
  logic             added;
  logic             dropped;
  logic             done_fire;
  logic             wr_en;

  tok_ctrl_t         chain_ctrl [TABLE_DEPTH+1];
  logic [EntryW-1:0] chain_page [TABLE_DEPTH+1];

  logic             out_valid_q, out_valid_d;
  logic             mismatch_q;
  logic             new_bad_page_q;
  logic [DataW-1:0] page_address_q;
  logic             table_overflow_q;
  logic [CountOutW-1:0] bad_page_count_q;
  logic [DataW-1:0] bad_word_total_q;
  logic             test_passed_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q   <= ExpectedReset;
      page_shift_q <= PageShiftReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgExpectedPattern: expected_q   <= cfg_data_i;
        CfgPageShift:       page_shift_q <= cfg_data_i[ShiftW-1:0];
        default: ;
      endcase
    end
  end

  assign accept  = in_valid_i && !in_stall_o;
  assign bad_in  = read_data_i != expected_q;
  assign page_in = word_address_i & AddrMask & ({DataW{1'b1}} << page_shift_q);

  always_comb begin
    in_stall_o = 1'b1;
    done_fire  = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_SEARCH: ;
      ST_DONE:   done_fire  = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = bad_in ? ST_SEARCH : ST_DONE;
        end
      end
      ST_SEARCH: begin
        if (chain_ctrl[TABLE_DEPTH].valid) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (done_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      page_q <= page_in;
      bad_q  <= bad_in;
      last_q <= last_word_i;
      hit_q  <= 1'b0;
    end else if ((state_q == ST_SEARCH) && chain_ctrl[TABLE_DEPTH].valid) begin
      hit_q <= chain_ctrl[TABLE_DEPTH].hit;
    end
  end

  assign chain_ctrl[0].valid = accept && bad_in;
  assign chain_ctrl[0].hit   = 1'b0;
  assign chain_page[0]       = page_in[EntryW-1:0];

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    mtbpl_cell #(
      .CELL_IDX (i),
      .ENTRY_W  (EntryW),
      .CNT_W    (CntW)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .tok_ctrl_i    (chain_ctrl[i]),
      .tok_page_i    (chain_page[i]),
      .tok_ctrl_o    (chain_ctrl[i+1]),
      .tok_page_o    (chain_page[i+1]),
      .entry_count_i (count_q),
      .wr_en_i       (wr_en),
      .wr_page_i     (page_q[EntryW-1:0])
    );
  end

  always_comb begin
    room     = count_q < CntW'(TABLE_DEPTH);
    new_page = bad_q && !hit_q;
    added    = new_page && room;
    dropped  = new_page && !room;
    count_d  = added ? count_q + CntW'(1) : count_q;
    total_d  = (bad_q && (total_q != CountTop)) ? total_q + DataW'(1) : total_q;
    wr_en    = done_fire && added;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
    end else if (done_fire) begin
      count_q <= count_d;
      total_q <= total_d;
    end
  end

  assign out_valid_d = done_fire ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      mismatch_q       <= bad_q;
      new_bad_page_q   <= added;
      page_address_q   <= page_q;
      table_overflow_q <= dropped;
      bad_page_count_q <= CountOutW'(count_d);
      bad_word_total_q <= total_d;
      test_passed_q    <= last_q && (total_d == '0);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign mismatch_o       = mismatch_q;
  assign new_bad_page_o   = new_bad_page_q;
  assign page_address_o   = page_address_q;
  assign table_overflow_o = table_overflow_q;
  assign bad_page_count_o = bad_page_count_q;
  assign bad_word_total_o = bad_word_total_q;
  assign test_passed_o    = test_passed_q;

endmodule

/* hdl/mtbpl_checker.sv */
module mtbpl_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic                            mismatch_o,
  input logic                            new_bad_page_o,
  input logic [mtbpl_pkg::DataW-1:0]     page_address_o,
  input logic                            table_overflow_o,
  input logic [mtbpl_pkg::DataW-1:0]     bad_word_total_o,
  input logic                            test_passed_o
);
  import mtbpl_pkg::*;

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result transaction withdrawn while stalled");

  a_out_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(page_address_o) && $stable(bad_word_total_o))
    else $error("result payload changed while stalled");

  a_page_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (new_bad_page_o || table_overflow_o) |->
      mismatch_o && !(new_bad_page_o && table_overflow_o))
    else $error("page flags inconsistent with mismatch");

  a_pass_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && test_passed_o |-> !mismatch_o && (bad_word_total_o == '0))
    else $error("pass reported with bad words counted");

  a_mismatch_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mismatch_o |-> bad_word_total_o != '0)
    else $error("bad word not counted");

endmodule

bind memory_test_bad_page_logger_top mtbpl_checker u_mtbpl_checker (.*);
